// File: sv/vpts_pkg.sv
// ----------------------------------------------------------------------------
// Vertex projection package
// Shared word types, item structs, coefficient map and saturating fixed-point
// helpers for the vertex projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vpts_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int COEF_DEPTH = 24;
    localparam int IDX_BITS   = 5;

    localparam int DIV_STEPS  = 2 * FRAC_BITS + 1;
    localparam int DIV_LAT    = DIV_STEPS + 1;
    localparam int EYE_LAT    = 5;
    localparam int PROJ_STG   = 3;
    localparam int PROJ_DELAY = DIV_LAT - PROJ_STG;
    localparam int VIEW_LAT   = 6;
    localparam int PIPE_DEPTH = EYE_LAT + DIV_LAT + VIEW_LAT;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    localparam int CI_P1  = 12;
    localparam int CI_P2  = 13;
    localparam int CI_P3  = 14;
    localparam int CI_P4  = 15;
    localparam int CI_P5  = 16;
    localparam int CI_P6  = 17;
    localparam int CI_VX0 = 18;
    localparam int CI_VY0 = 19;
    localparam int CI_VW  = 20;
    localparam int CI_VH  = 21;
    localparam int CI_VN  = 22;
    localparam int CI_VF  = 23;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic [COEF_DEPTH-1:0][WORD_BITS-1:0] t_coef;

    typedef struct packed {
        logic                 op;
        logic [IDX_BITS-1:0]  coef_index;
        logic signed [31:0]   coef_value;
        logic signed [31:0]   pos_x;
        logic signed [31:0]   pos_y;
        logic signed [31:0]   pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]   screen_x;
        logic signed [31:0]   screen_y;
        logic signed [31:0]   screen_depth;
        logic                 div_fault;
    } t_out_item;

    localparam t_word WORD_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word WORD_ONE  = t_word'(2**FRAC_BITS);
    localparam t_prod PROD_WMAX = t_prod'(WORD_MAX);
    localparam t_prod PROD_WMIN = t_prod'(WORD_MIN);
    localparam t_prod ROUND_ADJ = t_prod'(2**FRAC_BITS - 1);

    function automatic t_prod mul_full(input t_word a, input t_word b);
        t_prod pa;
        t_prod pb;
        pa = t_prod'(a);
        pb = t_prod'(b);
        return pa * pb;
    endfunction

    function automatic t_word scale_sat(input t_prod p);
        t_prod adj;
        t_prod q;
        adj = p[PROD_BITS-1] ? p + ROUND_ADJ : p;
        q   = adj >>> FRAC_BITS;
        if (q > PROD_WMAX) return WORD_MAX;
        if (q < PROD_WMIN) return WORD_MIN;
        return q[WORD_BITS-1:0];
    endfunction

    function automatic t_word add_sat(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic t_word sub_sat(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/vpts_eye.sv
// ----------------------------------------------------------------------------
// Eye-space transform
// Five stages: nine products, scaling, then three saturating sums per row.
// ----------------------------------------------------------------------------
`default_nettype none

module vpts_eye (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  vpts_pkg::t_word  i_pos_x,
    input  vpts_pkg::t_word  i_pos_y,
    input  vpts_pkg::t_word  i_pos_z,
    input  vpts_pkg::t_coef  i_coef,
    output logic             o_valid,
    output vpts_pkg::t_word  o_ex,
    output vpts_pkg::t_word  o_ey,
    output vpts_pkg::t_word  o_ez
);

    vpts_pkg::t_word pos [3];
    logic [vpts_pkg::EYE_LAT-1:0] r_vld;
    vpts_pkg::t_prod r1_prod [9];
    vpts_pkg::t_word r2_p [9];
    vpts_pkg::t_word r3_s [3];
    vpts_pkg::t_word r3_p [3];
    vpts_pkg::t_word r4_s [3];
    vpts_pkg::t_word r5_e [3];

    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[vpts_pkg::EYE_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_prod[3*r+c] <= vpts_pkg::mul_full(
                        vpts_pkg::t_word'(i_coef[4*r+c]), pos[c]);
                    r2_p[3*r+c] <= vpts_pkg::scale_sat(r1_prod[3*r+c]);
                end
                r3_s[r] <= vpts_pkg::add_sat(r2_p[3*r], r2_p[3*r+1]);
                r3_p[r] <= r2_p[3*r+2];
                r4_s[r] <= vpts_pkg::add_sat(r3_s[r], r3_p[r]);
                r5_e[r] <= vpts_pkg::add_sat(r4_s[r], vpts_pkg::t_word'(i_coef[4*r+3]));
            end
        end
    end

    assign o_valid = r_vld[vpts_pkg::EYE_LAT-1];
    assign o_ex    = r5_e[0];
    assign o_ey    = r5_e[1];
    assign o_ez    = r5_e[2];

endmodule

`default_nettype wire

// File: sv/vpts_recip.sv
// ----------------------------------------------------------------------------
// Perspective factor
// Pipelined restoring divider, one quotient bit per stage, for -(2^2F / z),
// followed by a sign, saturation and mode stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vpts_recip (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_mode,
    input  vpts_pkg::t_word  i_ez,
    output vpts_pkg::t_word  o_w,
    output logic             o_fault
);

    localparam int W = vpts_pkg::WORD_BITS;
    localparam int S = vpts_pkg::DIV_STEPS;
    localparam logic [S-1:0] QUO_MAX = {{(S-W+1){1'b0}}, {(W-1){1'b1}}};

    logic [W-1:0] mag;
    logic [W:0]   trial  [S];
    logic [W-1:0] den_in [S];
    logic [S-1:0] quo_in [S];
    logic [W-1:0] n_rem  [S];
    logic [S-1:0] n_quo  [S];
    logic [W-1:0] r_rem  [S];
    logic [S-1:0] r_quo  [S];
    logic [W-1:0] r_den  [S];
    logic         r_zpos [S];
    logic         r_zero [S];
    logic [S-1:0] q;
    vpts_pkg::t_word n_w;
    logic         n_fault;
    vpts_pkg::t_word r_w;
    logic         r_fault;

    always_comb begin
        mag = i_ez[W-1] ? (~i_ez + 1'b1) : i_ez;
        for (int k = 0; k < S; k++) begin
            if (k == 0) begin
                den_in[k] = mag;
                trial[k]  = {{W{1'b0}}, 1'b1};
                quo_in[k] = '0;
            end else begin
                den_in[k] = r_den[k-1];
                trial[k]  = {r_rem[k-1], 1'b0};
                quo_in[k] = r_quo[k-1];
            end
            if (trial[k] >= {1'b0, den_in[k]}) begin
                n_rem[k] = W'(trial[k] - {1'b0, den_in[k]});
                n_quo[k] = {quo_in[k][S-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[k][W-1:0];
                n_quo[k] = {quo_in[k][S-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < S; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= den_in[k];
            end
            r_zpos[0] <= !i_ez[W-1] && (i_ez != '0);
            r_zero[0] <= (i_ez == '0);
            for (int k = 1; k < S; k++) begin
                r_zpos[k] <= r_zpos[k-1];
                r_zero[k] <= r_zero[k-1];
            end
            r_w     <= n_w;
            r_fault <= n_fault;
        end
    end

    assign q = r_quo[S-1];

    always_comb begin
        n_fault = 1'b0;
        if (!i_mode) begin
            n_w = vpts_pkg::WORD_ONE;
        end else if (r_zero[S-1]) begin
            n_w     = vpts_pkg::WORD_MIN;
            n_fault = 1'b1;
        end else if (r_zpos[S-1]) begin
            n_w = (q > QUO_MAX) ? vpts_pkg::WORD_MIN : vpts_pkg::t_word'(~q[W-1:0] + 1'b1);
        end else begin
            n_w = (q > QUO_MAX) ? vpts_pkg::WORD_MAX : vpts_pkg::t_word'(q[W-1:0]);
        end
    end

    assign o_w     = r_w;
    assign o_fault = r_fault;

endmodule

`default_nettype wire

// File: sv/vpts_proj.sv
// ----------------------------------------------------------------------------
// Projection
// Products with the projection factors, scaling and sums, then a delay line
// that keeps the point aligned with the perspective factor.
// ----------------------------------------------------------------------------
`default_nettype none

module vpts_proj (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_mode,
    input  logic             i_valid,
    input  vpts_pkg::t_word  i_ex,
    input  vpts_pkg::t_word  i_ey,
    input  vpts_pkg::t_word  i_ez,
    input  vpts_pkg::t_coef  i_coef,
    output logic             o_valid,
    output vpts_pkg::t_word  o_px,
    output vpts_pkg::t_word  o_py,
    output vpts_pkg::t_word  o_pz
);

    localparam int D = vpts_pkg::PROJ_DELAY;

    logic [vpts_pkg::PROJ_STG-1:0] r_vld;
    vpts_pkg::t_prod r1_a, r1_b, r1_c, r1_d, r1_e;
    vpts_pkg::t_word r2_a, r2_b, r2_c, r2_d, r2_e;
    vpts_pkg::t_word r3_px, r3_py, r3_pz;
    logic [D-1:0]    r_dvld;
    vpts_pkg::t_word r_dpx [D];
    vpts_pkg::t_word r_dpy [D];
    vpts_pkg::t_word r_dpz [D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_dvld <= '0;
        end else if (i_en) begin
            r_vld  <= {r_vld[vpts_pkg::PROJ_STG-2:0], i_valid};
            r_dvld <= {r_dvld[D-2:0], r_vld[vpts_pkg::PROJ_STG-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a  <= vpts_pkg::mul_full(i_ex, vpts_pkg::t_word'(i_coef[vpts_pkg::CI_P1]));
            r1_b  <= vpts_pkg::mul_full(i_ez, vpts_pkg::t_word'(i_coef[vpts_pkg::CI_P2]));
            r1_c  <= vpts_pkg::mul_full(i_ey, vpts_pkg::t_word'(i_coef[vpts_pkg::CI_P3]));
            r1_d  <= vpts_pkg::mul_full(i_ez, vpts_pkg::t_word'(i_coef[vpts_pkg::CI_P4]));
            r1_e  <= vpts_pkg::mul_full(i_ez, vpts_pkg::t_word'(i_coef[vpts_pkg::CI_P5]));
            r2_a  <= vpts_pkg::scale_sat(r1_a);
            r2_b  <= vpts_pkg::scale_sat(r1_b);
            r2_c  <= vpts_pkg::scale_sat(r1_c);
            r2_d  <= vpts_pkg::scale_sat(r1_d);
            r2_e  <= vpts_pkg::scale_sat(r1_e);
            r3_px <= vpts_pkg::add_sat(r2_a,
                     i_mode ? r2_b : vpts_pkg::t_word'(i_coef[vpts_pkg::CI_P2]));
            r3_py <= vpts_pkg::add_sat(r2_c,
                     i_mode ? r2_d : vpts_pkg::t_word'(i_coef[vpts_pkg::CI_P4]));
            r3_pz <= vpts_pkg::add_sat(r2_e, vpts_pkg::t_word'(i_coef[vpts_pkg::CI_P6]));
            r_dpx[0] <= r3_px;
            r_dpy[0] <= r3_py;
            r_dpz[0] <= r3_pz;
            for (int k = 1; k < D; k++) begin
                r_dpx[k] <= r_dpx[k-1];
                r_dpy[k] <= r_dpy[k-1];
                r_dpz[k] <= r_dpz[k-1];
            end
        end
    end

    assign o_valid = r_dvld[D-1];
    assign o_px    = r_dpx[D-1];
    assign o_py    = r_dpy[D-1];
    assign o_pz    = r_dpz[D-1];

endmodule

`default_nettype wire

// File: sv/vpts_view.sv
// ----------------------------------------------------------------------------
// Viewport mapping
// Scale by the perspective factor, map to the viewport and hold the result
// in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vpts_view (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  vpts_pkg::t_word     i_px,
    input  vpts_pkg::t_word     i_py,
    input  vpts_pkg::t_word     i_pz,
    input  vpts_pkg::t_word     i_w,
    input  logic                i_fault,
    input  vpts_pkg::t_coef     i_coef,
    output logic                o_valid,
    output vpts_pkg::t_out_item o_item
);

    vpts_pkg::t_word vw, vh, vn, vf, vx0, vy0;
    logic [vpts_pkg::VIEW_LAT-1:0] r_vld;
    logic [vpts_pkg::VIEW_LAT-1:0] r_flt;
    vpts_pkg::t_prod r1_a, r1_b, r1_c;
    vpts_pkg::t_word r2_a, r2_b, r2_c, r2_fz;
    vpts_pkg::t_prod r3_a, r3_b, r3_c;
    vpts_pkg::t_word r4_a, r4_b, r4_c;
    vpts_pkg::t_word r5_x, r5_y, r5_z;
    vpts_pkg::t_word r6_x, r6_y, r6_z;

    assign vx0 = vpts_pkg::t_word'(i_coef[vpts_pkg::CI_VX0]);
    assign vy0 = vpts_pkg::t_word'(i_coef[vpts_pkg::CI_VY0]);
    assign vw  = vpts_pkg::t_word'(i_coef[vpts_pkg::CI_VW]);
    assign vh  = vpts_pkg::t_word'(i_coef[vpts_pkg::CI_VH]);
    assign vn  = vpts_pkg::t_word'(i_coef[vpts_pkg::CI_VN]);
    assign vf  = vpts_pkg::t_word'(i_coef[vpts_pkg::CI_VF]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[vpts_pkg::VIEW_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flt <= {r_flt[vpts_pkg::VIEW_LAT-2:0], i_fault};
            r1_a  <= vpts_pkg::mul_full(i_w, i_px);
            r1_b  <= vpts_pkg::mul_full(i_w, i_py);
            r1_c  <= vpts_pkg::mul_full(i_w, i_pz);
            r2_a  <= vpts_pkg::scale_sat(r1_a);
            r2_b  <= vpts_pkg::scale_sat(r1_b);
            r2_c  <= vpts_pkg::scale_sat(r1_c);
            r2_fz <= vpts_pkg::sub_sat(vf, vn);
            r3_a  <= vpts_pkg::mul_full(r2_a, vw);
            r3_b  <= vpts_pkg::mul_full(r2_b, vh);
            r3_c  <= vpts_pkg::mul_full(r2_c, r2_fz);
            r4_a  <= vpts_pkg::scale_sat(r3_a);
            r4_b  <= vpts_pkg::scale_sat(r3_b);
            r4_c  <= vpts_pkg::scale_sat(r3_c);
            r5_x  <= vpts_pkg::add_sat(r4_a, vw);
            r5_y  <= vpts_pkg::sub_sat(r4_b, vh);
            r5_z  <= vpts_pkg::add_sat(vf, r4_c);
            r6_x  <= vpts_pkg::add_sat(vx0, r5_x >>> 1);
            r6_y  <= vpts_pkg::sub_sat(vy0, r5_y >>> 1);
            r6_z  <= r5_z;
        end
    end

    assign o_valid             = r_vld[vpts_pkg::VIEW_LAT-1];
    assign o_item.screen_x     = r6_x;
    assign o_item.screen_y     = r6_y;
    assign o_item.screen_depth = r6_z;
    assign o_item.div_fault    = r_flt[vpts_pkg::VIEW_LAT-1];

endmodule

`default_nettype wire

// File: sv/vertex_project_to_screen.sv
// ----------------------------------------------------------------------------
// Vertex projection to screen
// Model-view transform, orthographic or perspective projection and viewport
// mapping of one vertex per cycle while the output is not stalled, Q16.16 throughout.
// ----------------------------------------------------------------------------
// A project item is taken every cycle while the pipeline does not hold, and
// passes 45 register stages (5 transform stages, 33 divider stages plus one,
// 6 viewport stages) before its result is presented; the pipelined
// bit-per-stage divider for -1/z sets that depth. A load item waits until every
// project item in flight has been transferred out, then writes the coefficient
// store and gives no result. The whole pipeline holds while a result waits at
// the output.
`default_nettype none

module vertex_project_to_screen (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  vpts_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output vpts_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    localparam int CNT_BITS = $clog2(vpts_pkg::PIPE_DEPTH + 1);

    logic                r_mode;
    vpts_pkg::t_coef     r_coef;
    logic [CNT_BITS-1:0] r_inflight;
    logic [CNT_BITS-1:0] n_inflight;
    logic                en;
    logic                in_xfer;
    logic                out_xfer;
    logic                proj_in;
    logic                eye_valid;
    vpts_pkg::t_word     ex, ey, ez;
    logic                proj_valid;
    vpts_pkg::t_word     px, py, pz;
    vpts_pkg::t_word     w;
    logic                fault;

    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en || (i_in_data.op == vpts_pkg::OP_LOAD && r_inflight != '0);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign proj_in     = in_xfer && i_in_data.op == vpts_pkg::OP_PROJECT;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_inflight = r_inflight;
        if (proj_in && !out_xfer) begin
            n_inflight = r_inflight + 1'b1;
        end else if (!proj_in && out_xfer) begin
            n_inflight = r_inflight - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in_data.op == vpts_pkg::OP_LOAD &&
            i_in_data.coef_index < vpts_pkg::IDX_BITS'(vpts_pkg::COEF_DEPTH)) begin
            r_coef[i_in_data.coef_index] <= i_in_data.coef_value;
        end
    end

    vpts_eye u_eye (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (proj_in),
        .i_pos_x (i_in_data.pos_x),
        .i_pos_y (i_in_data.pos_y),
        .i_pos_z (i_in_data.pos_z),
        .i_coef  (r_coef),
        .o_valid (eye_valid),
        .o_ex    (ex),
        .o_ey    (ey),
        .o_ez    (ez)
    );

    vpts_recip u_recip (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mode  (r_mode),
        .i_ez    (ez),
        .o_w     (w),
        .o_fault (fault)
    );

    vpts_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_mode  (r_mode),
        .i_valid (eye_valid),
        .i_ex    (ex),
        .i_ey    (ey),
        .i_ez    (ez),
        .i_coef  (r_coef),
        .o_valid (proj_valid),
        .o_px    (px),
        .o_py    (py),
        .o_pz    (pz)
    );

    vpts_view u_view (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (proj_valid),
        .i_px    (px),
        .i_py    (py),
        .i_pz    (pz),
        .i_w     (w),
        .i_fault (fault),
        .i_coef  (r_coef),
        .o_valid (o_out_valid),
        .o_item  (o_out_data)
    );

endmodule

`default_nettype wire

// File: sv/vpts_checker.sv
// ----------------------------------------------------------------------------
// Vertex projection port checker
// Port-level properties of the projection block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vpts_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  vpts_pkg::t_in_item  i_in_data,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  vpts_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    input  logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_load_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_data.op == vpts_pkg::OP_LOAD && o_out_valid) |-> o_in_stall)
        else $error("load transfer taken with a result pending");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input transfer taken while output held");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> (o_cfg_ready || $stable(i_cfg_data)))
        else $error("configuration write dropped");

endmodule

bind vertex_project_to_screen vpts_checker u_vpts_checker (.*);

`default_nettype wire
